// ===== hdl/elr_pkg.sv =====
// ----------------------------------------------------------------------------
// elr_pkg
// Shared widths, codes, payload types and the controller/datapath command
// and status structs of the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package elr_pkg;

  localparam int AXIS_BITS = 9;
  localparam int CRD_W     = AXIS_BITS + 1;      // cur_x / cur_y
  localparam int SQ_W      = 2 * AXIS_BITS;      // a^2, b^2
  localparam int RUN_W     = 3 * AXIS_BITS + 1;  // running b^2*x, a^2*y
  localparam int MA_W      = 2 * AXIS_BITS;      // multiplier operand A
  localparam int MB_W      = 2 * AXIS_BITS + 4;  // multiplier operand B
  localparam int DEC_W     = MA_W + MB_W;        // decision and product
  localparam int PIX_W     = 12;
  localparam int CEN_W     = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CEN_W-1:0]     CENTER_RESET = CEN_W'(100);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = CFG_IDX_W'(1);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [1:0] PIX_LAST = 2'd3;

  typedef struct packed {
    logic                 cmd;
    logic [AXIS_BITS-1:0] semi_a;
    logic [AXIS_BITS-1:0] semi_b;
  } elr_in_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    last_of_step;
    logic                    finished;
  } elr_out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,   // latch b, x=0, y=b, clear b^2*x, multiply a*a
    OP_ASQ,    // store a^2, multiply b*b
    OP_BSQ,    // store b^2, multiply a^2*b
    OP_AY,     // store a^2*y
    OP_SDEC,   // initial region-one decision
    OP_TX,     // multiply (2x+1)^2
    OP_BTX,    // multiply b^2*(2x+1)^2
    OP_TY,     // decision = b^2 term, multiply (y-1)^2
    OP_ATY,    // multiply a^2*(y-1)^2
    OP_ABB,    // add 4a^2(y-1)^2, multiply a^2*b^2
    OP_FIX,    // subtract 4a^2b^2, enter region two
    OP_R1M,    // region-one coordinate move
    OP_R1D,    // region-one decision update
    OP_R2M,    // region-two coordinate move
    OP_R2D,    // region-two decision update
    OP_EMIT    // load one pixel into the output register
  } elr_op_t;

  typedef struct packed {
    elr_op_t    op;
    logic [1:0] pix_idx;
  } elr_cmd_t;

  typedef struct packed {
    logic active;
    logic in_r2;
    logic r1_go;
    logic slot_free;
  } elr_stat_t;

endpackage

// ===== hdl/elr_ctrl.sv =====
// ----------------------------------------------------------------------------
// elr_ctrl
// Sequencer: accepts items, walks the datapath through the start, region
// change and step sequences, then hands four pixels to the output register.
// ----------------------------------------------------------------------------
module elr_ctrl import elr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_cmd,
  output logic      in_stall,
  input  elr_stat_t stat,
  output elr_cmd_t  cmd
);

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_ASQ  = 16'h0002,
    ST_BSQ  = 16'h0004,
    ST_AY   = 16'h0008,
    ST_SDEC = 16'h0010,
    ST_TX   = 16'h0020,
    ST_BTX  = 16'h0040,
    ST_TY   = 16'h0080,
    ST_ATY  = 16'h0100,
    ST_ABB  = 16'h0200,
    ST_FIX  = 16'h0400,
    ST_R1M  = 16'h0800,
    ST_R1D  = 16'h1000,
    ST_R2M  = 16'h2000,
    ST_R2D  = 16'h4000,
    ST_EMIT = 16'h8000
  } elr_state_t;

  elr_state_t state_r, state_nxt;
  logic [1:0] pix_cnt_r, pix_cnt_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    pix_cnt_nxt = pix_cnt_r;
    cmd.op      = OP_NONE;
    cmd.pix_idx = pix_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_START) begin
            cmd.op    = OP_LOAD;
            state_nxt = ST_ASQ;
          end else if (stat.active) begin
            if (stat.r1_go) begin
              state_nxt = ST_R1M;
            end else if (stat.in_r2) begin
              state_nxt = ST_R2M;
            end else begin
              state_nxt = ST_TX;
            end
          end
        end
      end
      ST_ASQ: begin
        cmd.op    = OP_ASQ;
        state_nxt = ST_BSQ;
      end
      ST_BSQ: begin
        cmd.op    = OP_BSQ;
        state_nxt = ST_AY;
      end
      ST_AY: begin
        cmd.op    = OP_AY;
        state_nxt = ST_SDEC;
      end
      ST_SDEC: begin
        cmd.op    = OP_SDEC;
        state_nxt = ST_EMIT;
      end
      ST_TX: begin
        cmd.op    = OP_TX;
        state_nxt = ST_BTX;
      end
      ST_BTX: begin
        cmd.op    = OP_BTX;
        state_nxt = ST_TY;
      end
      ST_TY: begin
        cmd.op    = OP_TY;
        state_nxt = ST_ATY;
      end
      ST_ATY: begin
        cmd.op    = OP_ATY;
        state_nxt = ST_ABB;
      end
      ST_ABB: begin
        cmd.op    = OP_ABB;
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        cmd.op    = OP_FIX;
        state_nxt = ST_R2M;
      end
      ST_R1M: begin
        cmd.op    = OP_R1M;
        state_nxt = ST_R1D;
      end
      ST_R1D: begin
        cmd.op    = OP_R1D;
        state_nxt = ST_EMIT;
      end
      ST_R2M: begin
        cmd.op    = OP_R2M;
        state_nxt = ST_R2D;
      end
      ST_R2D: begin
        cmd.op    = OP_R2D;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.slot_free) begin
          cmd.op      = OP_EMIT;
          pix_cnt_nxt = pix_cnt_r + 2'd1;
          if (pix_cnt_r == PIX_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt   = ST_IDLE;
        pix_cnt_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pix_cnt_r <= 2'd0;
    end else begin
      state_r   <= state_nxt;
      pix_cnt_r <= pix_cnt_nxt;
    end
  end

endmodule

// ===== hdl/elr_dp.sv =====
// ----------------------------------------------------------------------------
// elr_dp
// Datapath: center registers, point and decision registers, running
// products b^2*x and a^2*y, one shared registered multiplier and the
// output register.
// ----------------------------------------------------------------------------
module elr_dp import elr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  elr_in_t              in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CEN_W-1:0]     cfg_data,
  input  elr_cmd_t             cmd,
  output elr_stat_t            stat,
  input  logic                 out_stall,
  output logic                 out_valid,
  output elr_out_t             out_data
);

  logic [CEN_W-1:0]     cx_r, cy_r;
  logic [AXIS_BITS-1:0] b_r;
  logic [CRD_W-1:0]     x_r, y_r;
  logic [SQ_W-1:0]      asq_r, bsq_r;
  logic [RUN_W-1:0]     bx_r, ay_r;
  logic [DEC_W-1:0]     prod_r;
  logic signed [DEC_W-1:0] d_r, d_nxt;
  logic                 br_r;
  logic                 r2_r, act_r, fin_r;
  logic                 out_vld_r;
  elr_out_t             out_r, pix;

  logic [MA_W-1:0]      mul_a;
  logic [MB_W-1:0]      mul_b;
  logic [CRD_W:0]       tx;
  logic [CRD_W-1:0]     ty;
  logic signed [DEC_W-1:0] bx_s, ay_s, asq_s, bsq_s, prod_s;
  logic [PIX_W-1:0]     cxe, cye, xe, ye;

  assign tx = {x_r, 1'b1};
  assign ty = y_r - CRD_W'(1);

  assign bx_s   = signed'(DEC_W'(bx_r));
  assign ay_s   = signed'(DEC_W'(ay_r));
  assign asq_s  = signed'(DEC_W'(asq_r));
  assign bsq_s  = signed'(DEC_W'(bsq_r));
  assign prod_s = signed'(prod_r);

  assign stat.active    = act_r;
  assign stat.in_r2     = r2_r;
  assign stat.r1_go     = act_r && !r2_r && (bx_r <= ay_r);
  assign stat.slot_free = !out_vld_r || !out_stall;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_LOAD: begin
        mul_a = MA_W'(in_data.semi_a);
        mul_b = MB_W'(in_data.semi_a);
      end
      OP_ASQ: begin
        mul_a = MA_W'(b_r);
        mul_b = MB_W'(b_r);
      end
      OP_BSQ: begin
        mul_a = MA_W'(asq_r);
        mul_b = MB_W'(b_r);
      end
      OP_TX: begin
        mul_a = MA_W'(tx);
        mul_b = MB_W'(tx);
      end
      OP_BTX: begin
        mul_a = MA_W'(bsq_r);
        mul_b = prod_r[MB_W-1:0];
      end
      OP_TY: begin
        mul_a = MA_W'(ty);
        mul_b = MB_W'(ty);
      end
      OP_ATY: begin
        mul_a = MA_W'(asq_r);
        mul_b = prod_r[MB_W-1:0];
      end
      OP_ABB: begin
        mul_a = MA_W'(asq_r);
        mul_b = MB_W'(bsq_r);
      end
      default: ;
    endcase
  end

  // decision variable, kept scaled by 4; updates use the moved x and y
  always_comb begin
    d_nxt = d_r;
    unique case (cmd.op)
      OP_SDEC: d_nxt = (bsq_s <<< 2) - (ay_s <<< 2) + asq_s;
      OP_TY:   d_nxt = prod_s;
      OP_ABB:  d_nxt = d_r + (prod_s <<< 2);
      OP_FIX:  d_nxt = d_r - (prod_s <<< 2);
      OP_R1D: begin
        if (br_r) begin
          d_nxt = d_r + (bx_s <<< 3) + (bsq_s <<< 2);
        end else begin
          d_nxt = d_r + (bx_s <<< 3) - (ay_s <<< 3) + (bsq_s <<< 2);
        end
      end
      OP_R2D: begin
        if (br_r) begin
          d_nxt = d_r + (asq_s <<< 2) - (ay_s <<< 3);
        end else begin
          d_nxt = d_r + (bx_s <<< 3) - (ay_s <<< 3) + (asq_s <<< 2);
        end
      end
      default: ;
    endcase
  end

  // mirrored pixel: index bit 1 negates x, bit 0 negates y
  assign cxe = PIX_W'(cx_r);
  assign cye = PIX_W'(cy_r);
  assign xe  = PIX_W'(x_r);
  assign ye  = PIX_W'(y_r);

  always_comb begin
    pix.pixel_x      = signed'(cmd.pix_idx[1] ? (cxe - xe) : (cxe + xe));
    pix.pixel_y      = signed'(cmd.pix_idx[0] ? (cye - ye) : (cye + ye));
    pix.last_of_step = (cmd.pix_idx == PIX_LAST);
    pix.finished     = fin_r;
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    d_r    <= d_nxt;
    unique case (cmd.op)
      OP_LOAD: begin
        b_r  <= in_data.semi_b;
        x_r  <= '0;
        y_r  <= CRD_W'(in_data.semi_b);
        bx_r <= '0;
      end
      OP_ASQ: asq_r <= prod_r[SQ_W-1:0];
      OP_BSQ: bsq_r <= prod_r[SQ_W-1:0];
      OP_AY:  ay_r  <= prod_r[RUN_W-1:0];
      OP_R1M: begin
        br_r <= d_r < 0;
        x_r  <= x_r + CRD_W'(1);
        bx_r <= bx_r + RUN_W'(bsq_r);
        if (d_r >= 0) begin
          y_r  <= y_r - CRD_W'(1);
          ay_r <= ay_r - RUN_W'(asq_r);
        end
      end
      OP_R2M: begin
        br_r <= d_r > 0;
        y_r  <= y_r - CRD_W'(1);
        ay_r <= ay_r - RUN_W'(asq_r);
        if (d_r <= 0) begin
          x_r  <= x_r + CRD_W'(1);
          bx_r <= bx_r + RUN_W'(bsq_r);
        end
      end
      OP_SDEC, OP_R1D, OP_R2D: fin_r <= (y_r == '0);
      OP_EMIT: out_r <= pix;
      default: ;
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r      <= CENTER_RESET;
      cy_r      <= CENTER_RESET;
      r2_r      <= 1'b0;
      act_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == REG_CENTER_X)) begin
        cx_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == REG_CENTER_Y)) begin
        cy_r <= cfg_data;
      end
      if (cmd.op == OP_LOAD) begin
        r2_r <= 1'b0;
      end else if (cmd.op == OP_FIX) begin
        r2_r <= 1'b1;
      end
      if (cmd.op == OP_SDEC || cmd.op == OP_R1D || cmd.op == OP_R2D) begin
        act_r <= (y_r != '0);
      end
      if (cmd.op == OP_EMIT) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/ellipse_rasterizer.sv =====
// ----------------------------------------------------------------------------
// ellipse_rasterizer
// Midpoint rasterizer for an axis-aligned ellipse about a programmable
// center, emitting four mirrored pixels per accepted item.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data): cmd START loads semi_a and
//   semi_b and emits the first four pixels; cmd STEP advances one point. A
//   step while no ellipse is in progress is taken and produces nothing.
// Output channel (out_valid / out_stall / out_data): four pixels per item in
//   the order (+x,+y) (+x,-y) (-x,+y) (-x,-y); last_of_step marks the fourth,
//   finished marks every pixel of the item that brought y to zero.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): center_x at
//   index 0, center_y at index 1; always ready, write only while idle.
// Throughput: one item at a time through a shared registered multiplier.
//   A step runs accept, the move and decision-update states, then an emit
//   state per pixel; the step that crosses into region two first runs the
//   setup multiplies; a start runs load, a^2, b^2, a^2*y and the initial
//   decision before its pixels.
// A stalled output holds its pixel and pauses the sequencer; the next
//   item is accepted while the last pixel still waits.
// Reset: centers return to 100, no ellipse is active, output empties.
// ----------------------------------------------------------------------------
module ellipse_rasterizer import elr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  elr_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output elr_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CEN_W-1:0]     cfg_data
);

  elr_cmd_t  cmd;
  elr_stat_t stat;

  assign cfg_ready = 1'b1;

  elr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  elr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // a start always makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.cmd == CMD_START) |=> in_stall)
    else $error("start transaction did not occupy the sequencer");

  // a pixel is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |-> (!out_valid || !out_stall))
    else $error("output register overwritten");

  // the four pixels of an item leave back to back
  a_pix_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last_of_step) |=> out_valid)
    else $error("gap inside a pixel group");
`endif

endmodule
